// File: src/kmp_pkg.sv
// shared constants and types for the kmp prefix string matcher
// used by kmp_ctrl and kmp_prefix_string_matcher_core; no dependencies
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN   = 256;
    localparam int ADDR_W        = $clog2(MAX_PATTERN);
    localparam int CNT_W         = $clog2(MAX_PATTERN + 1);
    localparam int POSITION_BITS = 32;
    localparam int SYM_W         = 8;
    localparam int START_W       = 32;

    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // one memory port pair: a write and a read address
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic               match;
        logic [START_W-1:0] start;
    } result_t;

endpackage

`default_nettype wire

// File: src/kmp_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// generic; no package dependencies
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/kmp_ctrl.sv
// sequencer for pattern loading and text search; drives the pattern and table rams
// depends on kmp_pkg
`default_nettype none

module kmp_ctrl
    import kmp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_func,
    input  wire logic [SYM_W-1:0]  in_symbol,
    input  wire logic              in_last,
    output mem_req_t               store_req,
    output logic      [SYM_W-1:0]  store_wdata,
    input  wire logic [SYM_W-1:0]  store_q,
    output mem_req_t               table_req,
    output logic      [ADDR_W-1:0] table_wdata,
    input  wire logic [ADDR_W-1:0] table_q,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PFETCH = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_FBACK  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         mlen_reg, mlen_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     reload_reg, reload_next;
    logic                     hit_reg, hit_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic                     func_reg, func_next;
    logic [SYM_W-1:0]         sym_reg, sym_next;
    logic                     last_reg, last_next;
    logic [START_W-1:0]       start_reg, start_next;

    logic [CNT_W-1:0] k_eff;
    logic [CNT_W-1:0] j_start;
    logic [CNT_W-1:0] jn;
    logic             sym_eq;

    assign k_eff   = reload_reg ? '0 : count_reg;
    assign j_start = (mlen_reg >= count_reg) ? '0 : mlen_reg;
    assign sym_eq  = (sym_reg == store_q);
    assign jn      = sym_eq ? CNT_W'(j_reg + 1'b1) : '0;

    assign in_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_EMIT);
    assign res.match   = hit_reg;
    assign res.start   = hit_reg ? start_reg : '0;
    // pattern bytes are written in the accepting cycle
    assign store_wdata = in_symbol;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        mlen_next   = mlen_reg;
        pos_next    = pos_reg;
        reload_next = reload_reg;
        hit_next    = hit_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        func_next   = func_reg;
        sym_next    = sym_reg;
        last_next   = last_reg;
        start_next  = start_reg;
        store_req   = '0;
        table_req   = '0;
        table_wdata = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    func_next = in_func;
                    sym_next  = in_symbol;
                    last_next = in_last;
                    hit_next  = 1'b0;
                    if (in_func == FUNC_PATTERN) begin
                        reload_next = 1'b0;
                        mlen_next   = '0;
                        pos_next    = '0;
                        count_next  = k_eff;
                        k_next      = k_eff;
                        if (k_eff >= CNT_W'(MAX_PATTERN)) begin
                            state_next = S_EMIT;
                        end else if (k_eff == '0) begin
                            // first byte: its table entry is zero
                            store_req.we    = 1'b1;
                            store_req.waddr = '0;
                            table_req.we    = 1'b1;
                            table_req.waddr = '0;
                            count_next      = CNT_W'(1);
                            state_next      = S_EMIT;
                        end else begin
                            store_req.we    = 1'b1;
                            store_req.waddr = k_eff[ADDR_W-1:0];
                            table_req.raddr = ADDR_W'(k_eff - 1'b1);
                            state_next      = S_PFETCH;
                        end
                    end else begin
                        reload_next = 1'b1;
                        start_next  = START_W'(pos_reg
                                      - POSITION_BITS'(CNT_W'(count_reg - 1'b1)));
                        if (in_last) begin
                            pos_next = '0;
                        end else if (pos_reg != {POSITION_BITS{1'b1}}) begin
                            pos_next = pos_reg + 1'b1;
                        end
                        if (count_reg == '0) begin
                            if (in_last) begin
                                mlen_next = '0;
                            end
                            state_next = S_EMIT;
                        end else begin
                            j_next          = j_start;
                            store_req.raddr = j_start[ADDR_W-1:0];
                            table_req.raddr = ADDR_W'(j_start - 1'b1);
                            state_next      = S_WALK;
                        end
                    end
                end
            end
            S_PFETCH: begin
                // walk for the new entry starts at the previous table value
                j_next          = CNT_W'(table_q);
                store_req.raddr = table_q;
                table_req.raddr = ADDR_W'(table_q - 1'b1);
                state_next      = S_WALK;
            end
            S_WALK: begin
                if (!sym_eq && j_reg != '0) begin
                    // fall back and read the shorter prefix next cycle
                    j_next          = CNT_W'(table_q);
                    store_req.raddr = table_q;
                    table_req.raddr = ADDR_W'(table_q - 1'b1);
                end else if (func_reg == FUNC_PATTERN) begin
                    table_req.we    = 1'b1;
                    table_req.waddr = k_reg[ADDR_W-1:0];
                    table_wdata     = jn[ADDR_W-1:0];
                    count_next      = CNT_W'(k_reg + 1'b1);
                    state_next      = S_EMIT;
                end else if (jn == count_reg) begin
                    table_req.raddr = ADDR_W'(count_reg - 1'b1);
                    state_next      = S_FBACK;
                end else begin
                    mlen_next  = last_reg ? '0 : jn;
                    state_next = S_EMIT;
                end
            end
            S_FBACK: begin
                hit_next   = 1'b1;
                mlen_next  = last_reg ? '0 : CNT_W'(table_q);
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mlen_reg   <= '0;
            pos_reg    <= '0;
            reload_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mlen_reg   <= mlen_next;
            pos_reg    <= pos_next;
            reload_reg <= reload_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg     <= j_next;
        k_reg     <= k_next;
        func_reg  <= func_next;
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        start_reg <= start_next;
    end

`ifndef SYNTHESIS
    a_walk_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (j_reg < count_reg))
        else $error("walk length reached pattern length");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PATTERN))
        else $error("pattern count above capacity");

    a_fback_text_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FBACK) |-> (func_reg == FUNC_TEXT))
        else $error("match fallback on a pattern word");

    a_pattern_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_func == FUNC_PATTERN)
        |=> (mlen_reg == '0 && pos_reg == '0))
        else $error("pattern word left search state");

    a_hit_only_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.match) |-> (func_reg == FUNC_TEXT && count_reg != '0))
        else $error("match reported without a pattern");
`endif

endmodule

`default_nettype wire

// File: src/kmp_prefix_string_matcher_core.sv
// streaming kmp matcher: sequencer, pattern and prefix-table rams, output register
// depends on kmp_pkg, kmp_ram, kmp_ctrl
//
// usage: the s_ channel takes one byte word at a time. s_tuser = 0 loads a pattern
// byte (the first one after any text byte starts a new pattern), s_tuser = 1 searches
// a text byte; s_tlast on a text word clears match length and text offset afterwards.
// every accepted word yields exactly one m_ word: m_tuser = 1 when an occurrence of
// the pattern ends at that text byte, m_tdata = its start offset (zero otherwise).
// pattern words and text words with no pattern always answer with no match.
// timing: the block works on one word at a time. a first or ignored pattern byte, or a
// text byte with no pattern, goes straight to its result; any other pattern byte reads
// the previous table entry, then takes w compare steps, and any other text byte takes w
// compare steps plus a table read on a match; the w compare steps run one per cycle on
// the ram read ports, at least one and under two per byte amortized. s_tready is low
// during that work and rises once the result is taken into the output register.
// the output register holds one result, so the next word is taken while a result
// waits; a stalled m_tready holds the following result inside and stops intake.
// reset (aresetn low, synchronous) empties the pattern and clears all search state;
// the rams need no clearing since only loaded entries are ever read.
`default_nettype none

module kmp_prefix_string_matcher_core
    import kmp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SYM_W-1:0]   s_tdata,   // symbol
    input  wire logic               s_tuser,   // func
    input  wire logic               s_tlast,   // last
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [START_W-1:0] m_tdata,   // match_start
    output logic                    m_tuser    // match
);

    mem_req_t            store_req;
    mem_req_t            table_req;
    logic [SYM_W-1:0]    store_wdata;
    logic [SYM_W-1:0]    store_q;
    logic [ADDR_W-1:0]   table_wdata;
    logic [ADDR_W-1:0]   table_q;
    logic                res_valid;
    logic                res_ready;
    result_t             res;

    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_tuser_reg, m_tuser_next;
    logic [START_W-1:0]  m_tdata_reg, m_tdata_next;

    kmp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_symbol   (s_tdata),
        .in_last     (s_tlast),
        .store_req   (store_req),
        .store_wdata (store_wdata),
        .store_q     (store_q),
        .table_req   (table_req),
        .table_wdata (table_wdata),
        .table_q     (table_q),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    kmp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .aclk  (aclk),
        .we    (store_req.we),
        .waddr (store_req.waddr),
        .wdata (store_wdata),
        .raddr (store_req.raddr),
        .rdata (store_q)
    );

    kmp_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_PATTERN)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (table_req.we),
        .waddr (table_req.waddr),
        .wdata (table_wdata),
        .raddr (table_req.raddr),
        .rdata (table_q)
    );

    // output register refills in the cycle its word leaves
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            m_tuser_next  = res.match;
            m_tdata_next  = res.start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: sim/kmp_prefix_string_matcher_core_tb.sv
// self-checking testbench for kmp_prefix_string_matcher_core: directed table, then random
// pattern/text runs under several idle and stall mixes; depends on kmp_pkg and the rtl
`timescale 1ns / 100ps

module kmp_prefix_string_matcher_core_tb
    import kmp_pkg::*;
();

    localparam int N_DIR          = 24;
    localparam int RANDOM_WORDS   = 476;
    localparam int LONG_TEXT      = 40;
    localparam int TAIL_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int SEND_IDLE_PCT  [4] = '{0, 46, 0, 22};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 46, 22};

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic             func;
        logic [SYM_W-1:0] symbol;
        logic             is_last;
        logic             typed;
        logic             hit;
        logic [START_W-1:0] start;
    } dir_row_t;

    typedef struct {
        logic             func;
        logic [SYM_W-1:0] symbol;
        logic             is_last;
        bit               typed;
        result_t          want;
        int               phase;
    } stim_word_t;

    localparam dir_row_t DIR_TABLE [N_DIR] = '{
        // text with no pattern loaded, then the empty pattern with last
        '{FUNC_TEXT,    8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b1, 1'b1, 1'b0, 32'd0},
        // pattern 00 ff 00, first byte follows text so a new pattern starts
        '{FUNC_PATTERN, 8'h00, 1'b0, 1'b1, 1'b0, 32'd0},
        '{FUNC_PATTERN, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
        '{FUNC_PATTERN, 8'h00, 1'b0, 1'b1, 1'b0, 32'd0},
        // overlapping hits, then last clears the search
        '{FUNC_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b1, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        // last on a pattern byte is ignored
        '{FUNC_PATTERN, 8'h61, 1'b1, 1'b1, 1'b0, 32'd0},
        '{FUNC_PATTERN, 8'h61, 1'b0, 1'b1, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h61, 1'b1, 1'b0, 1'b0, 32'd0},
        // single-byte pattern
        '{FUNC_PATTERN, 8'h80, 1'b0, 1'b1, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h7F, 1'b0, 1'b0, 1'b0, 32'd0},
        '{FUNC_TEXT,    8'h80, 1'b1, 1'b0, 1'b0, 32'd0}
    };

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SYM_W-1:0]   s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [START_W-1:0] m_tdata;
    logic               m_tuser;

    kmp_prefix_string_matcher_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    stim_word_t stim_q [$];
    stim_word_t shown_word;
    result_t    expected_q [$];
    int         send_idx    = 0;
    int         cur_phase   = 0;
    bit         stim_ready  = 1'b0;
    bit         s_fire      = 1'b0;
    int         n_errors    = 0;
    int         n_pattern   = 0;
    int         n_text      = 0;
    int         n_hits      = 0;
    int         n_results   = 0;

    // matcher state as the predictor sees it
    logic [SYM_W-1:0]         pat_bytes [MAX_PATTERN];
    logic [ADDR_W-1:0]        fail_link [MAX_PATTERN];
    logic [CNT_W-1:0]         pat_len         = '0;
    logic [CNT_W-1:0]         run_len         = '0;
    logic [POSITION_BITS-1:0] text_off        = '0;
    logic                     new_pattern_due = 1'b0;

    // fall back through the failure links until c extends the partial match
    function automatic logic [CNT_W-1:0] walk_back(logic [CNT_W-1:0] j, logic [SYM_W-1:0] c);
        while (j != 0 && c != pat_bytes[j[ADDR_W-1:0]])
            j = CNT_W'(fail_link[ADDR_W'(j - 1'b1)]);
        if (c == pat_bytes[j[ADDR_W-1:0]])
            j = j + 1'b1;
        return j;
    endfunction

    function automatic result_t kmp_predict(logic func, logic [SYM_W-1:0] c, logic is_last);
        result_t          r;
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] j;
        r = '0;
        if (func == FUNC_PATTERN) begin
            if (new_pattern_due) begin
                pat_len         = '0;
                new_pattern_due = 1'b0;
            end
            run_len  = '0;
            text_off = '0;
            if (pat_len < MAX_PATTERN) begin
                k = pat_len;
                pat_bytes[k[ADDR_W-1:0]] = c;
                if (k == 0) begin
                    fail_link[0] = '0;
                end else begin
                    fail_link[k[ADDR_W-1:0]] =
                        ADDR_W'(walk_back(CNT_W'(fail_link[ADDR_W'(k - 1'b1)]), c));
                end
                pat_len = k + 1'b1;
            end
        end else begin
            new_pattern_due = 1'b1;
            if (pat_len != 0) begin
                j = (run_len >= pat_len) ? '0 : run_len;
                j = walk_back(j, c);
                if (j == pat_len) begin
                    r.match = 1'b1;
                    r.start = START_W'(text_off - POSITION_BITS'(pat_len - 1'b1));
                    j = CNT_W'(fail_link[ADDR_W'(pat_len - 1'b1)]);
                end
                run_len = j;
            end
            if (text_off != '1)
                text_off = text_off + 1'b1;
            if (is_last) begin
                run_len  = '0;
                text_off = '0;
            end
        end
        return r;
    endfunction

    function automatic void add_word(logic func, logic [SYM_W-1:0] sym, logic is_last);
        stim_word_t w;
        w.func    = func;
        w.symbol  = sym;
        w.is_last = is_last;
        w.typed   = 1'b0;
        w.want    = '0;
        w.phase   = 0;
        stim_q    = {stim_q, w};
    endfunction

    // mostly from a small alphabet so hits happen, now and then any byte
    function automatic logic [SYM_W-1:0] pick_sym(logic [SYM_W-1:0] base, int alpha);
        if ($urandom_range(0, 9) == 0)
            return SYM_W'($urandom);
        return base + SYM_W'($urandom_range(0, alpha - 1));
    endfunction

    // sender: new word at the falling edge once the previous one was taken
    always @(negedge aclk) begin
        if (stim_ready && !(s_tvalid && !s_fire)) begin
            if (send_idx < stim_q.size() &&
                $urandom_range(0, 99) >= SEND_IDLE_PCT[stim_q[send_idx].phase]) begin
                shown_word = stim_q[send_idx];
                cur_phase  = stim_q[send_idx].phase;
                send_idx   = send_idx + 1;
                s_tvalid <= 1'b1;
                s_tdata  <= shown_word.symbol;
                s_tuser  <= shown_word.func;
                s_tlast  <= shown_word.is_last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[cur_phase]);
    end

    always @(posedge aclk) begin
        result_t want;
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            want = kmp_predict(s_tuser, s_tdata, s_tlast);
            if (shown_word.typed)
                want = shown_word.want;
            expected_q = {expected_q, want};
            if (s_tuser == FUNC_PATTERN)
                n_pattern++;
            else
                n_text++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tuser)
                n_hits++;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("[%0t] unexpected word: match %b start %0d", $realtime,
                             m_tuser, m_tdata);
            end else begin
                want = expected_q.pop_front();
                if (m_tuser !== want.match || m_tdata !== want.start) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("[%0t] word %0d: match exp %b got %b, start exp %0d got %0d",
                                 $realtime, n_results, want.match, m_tuser, want.start,
                                 m_tdata);
                end
            end
        end
    end

    initial begin
        stim_word_t       w;
        logic [SYM_W-1:0] pat [$];
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] b;
        int               alpha;
        int               plen;
        int               tlen;
        int               n;
        int               flip;
        bit               long_done;

        for (int i = 0; i < N_DIR; i++) begin
            w.func    = DIR_TABLE[i].func;
            w.symbol  = DIR_TABLE[i].symbol;
            w.is_last = DIR_TABLE[i].is_last;
            w.typed   = DIR_TABLE[i].typed;
            w.want.match = DIR_TABLE[i].hit;
            w.want.start = DIR_TABLE[i].start;
            w.phase   = 0;
            stim_q    = {stim_q, w};
        end

        long_done = 1'b0;
        while (stim_q.size() - N_DIR < RANDOM_WORDS) begin
            if (!long_done && stim_q.size() - N_DIR > 150) begin
                // overlong periodic pattern: only the first MAX_PATTERN bytes count
                base = SYM_W'($urandom);
                for (int i = 0; i < MAX_PATTERN + 2; i++)
                    add_word(FUNC_PATTERN, (i % 2) ? ~base : base, 1'b0);
                flip = $urandom_range(5, 30);
                for (int i = 0; i < LONG_TEXT; i++)
                    add_word(FUNC_TEXT, (i == flip) ? base + 8'd1 : ((i % 2) ? ~base : base),
                             i == LONG_TEXT - 1);
                long_done = 1'b1;
            end
            base  = SYM_W'($urandom);
            alpha = ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(1, 4);
            plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 5);
            pat.delete();
            for (int i = 0; i < plen; i++) begin
                b = pick_sym(base, alpha);
                pat = {pat, b};
                add_word(FUNC_PATTERN, b, $urandom_range(0, 7) == 0);
            end
            tlen = $urandom_range(4, 40);
            n = 0;
            while (n < tlen) begin
                if ($urandom_range(0, 1)) begin
                    // a copy of the pattern, sometimes with one byte broken
                    flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plen - 1) : -1;
                    for (int i = 0; i < plen; i++)
                        add_word(FUNC_TEXT, (i == flip) ? pat[i] ^ SYM_W'($urandom_range(1, 255))
                                                        : pat[i], 1'b0);
                    n += plen;
                end else begin
                    add_word(FUNC_TEXT, pick_sym(base, alpha), $urandom_range(0, 24) == 0);
                    n++;
                end
            end
            stim_q[stim_q.size() - 1].is_last = $urandom_range(0, 1);
        end

        for (int i = N_DIR; i < stim_q.size(); i++)
            stim_q[i].phase = (i - N_DIR) * 4 / (stim_q.size() - N_DIR);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        stim_ready = 1'b1;

        while (send_idx < stim_q.size() || s_tvalid)
            @(posedge aclk);
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d pattern and %0d text words, %0d hits, one overlong pattern,",
                 n_pattern, n_text, n_hits);
        $display("under free-running, sender-idle, receiver-stall and mixed pressure");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timed out with %0d results still expected", expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
